[rtl/rzad_pkg.sv]
// shared types and constants of the rolling z-score anomaly detector
// no dependencies
package rzad_pkg;

  localparam int DATA_W  = 24;
  localparam int ZLIM_W  = 16;
  localparam int WLEN_W  = 7;
  localparam int RUN_W   = 8;
  localparam int SCORE_W = 32;
  localparam int DEN_W   = DATA_W + ZLIM_W;
  localparam int NB_W    = 7;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  localparam logic [2:0] REG_HARD_LIMIT    = 3'd0;
  localparam logic [2:0] REG_STAT_FLOOR    = 3'd1;
  localparam logic [2:0] REG_MIN_DEVIATION = 3'd2;
  localparam logic [2:0] REG_Z_LIMIT       = 3'd3;
  localparam logic [2:0] REG_WINDOW_LEN    = 3'd4;
  localparam logic [2:0] REG_RUN_NEEDED    = 3'd5;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic            start;
    logic [NB_W-1:0] nbits;
  } div_req_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_MEAN = 9'b000000100,
    S_VAR  = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_DEN  = 9'b000100000,
    S_ZDIV = 9'b001000000,
    S_HDIV = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

endpackage

[rtl/rzad_ring.sv]
// baseline ring memory, one write port and one registered read port
// depends on rzad_pkg
module rzad_ring
  import rzad_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rzad_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on rzad_pkg
module rzad_div
  import rzad_pkg::*;
#(
  parameter int DVD_W = 64,
  parameter int DVS_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quo
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] q_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [CW-1:0]    sh;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign sh    = CW'(DVD_W) - CW'(req.nbits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(req.nbits);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dvd << sh;
      dvs_r <= dvs;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule

[rtl/rzad_sqrt.sv]
// integer square root, one result bit per cycle
// depends on rzad_pkg
module rzad_sqrt
  import rzad_pkg::*;
#(
  parameter int X_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [X_W-1:0]   x,
  output logic             done,
  output logic [X_W/2-1:0] root
);

  localparam int CW = $clog2(X_W / 2 + 1);

  logic [X_W-1:0] x_r;
  logic [X_W-1:0] res_r;
  logic [X_W-1:0] bit_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [X_W-1:0] tst;

  assign tst = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(X_W / 2);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      res_r <= '0;
      bit_r <= X_W'(1) << (X_W - 2);
    end else if (busy_r) begin
      if (x_r >= tst) begin
        x_r   <= x_r - tst;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[X_W/2-1:0];

endmodule

[rtl/rolling_zscore_anomaly_detector.sv]
// rolling z-score anomaly detector: one word in, one word out
// a sample word passes S_MUL, S_MEAN, S_VAR, S_SQRT, S_DEN, S_ZDIV, S_HDIV and S_FIN in turn;
// the four divisions (30, 61, 48, 40 bits at MAX_WINDOW 64) and the root (31 bits) each
// produce one bit a cycle; a missing sample goes straight to S_FIN
// one word at a time; the next word is taken while a result waits
// reset and any write to a listed register clear the baseline, sums and run count
module rolling_zscore_anomaly_detector
  import rzad_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_sample_value,
  input  logic              in_sample_valid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_trigger,
  output logic              out_anomalous,
  output logic [SCORE_W-1:0] out_score,
  output logic [DATA_W-1:0] out_baseline_mean,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = DATA_W + SLOT_W;
  localparam int SQ_W   = 2 * DATA_W + SLOT_W;
  localparam int A_W    = SQ_W + CNT_W;
  localparam int DVD_W  = (A_W > 2 * DATA_W) ? A_W : 2 * DATA_W;
  localparam int X_W    = DVD_W + (DVD_W % 2);

  // configuration
  logic [DATA_W-1:0] hard_limit_r, stat_floor_r, min_dev_r;
  logic [ZLIM_W-1:0] z_limit_r;
  logic [WLEN_W-1:0] window_len_r;
  logic [RUN_W-1:0]  run_needed_r;
  logic              cfg_wr, cfg_clr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_clr = cfg_wr && (cfg_idx <= REG_RUN_NEEDED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_limit_r <= DATA_W'(230);
      stat_floor_r <= DATA_W'(128);
      min_dev_r    <= DATA_W'(3);
      z_limit_r    <= ZLIM_W'(768);
      window_len_r <= WLEN_W'(30);
      run_needed_r <= RUN_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HARD_LIMIT:    hard_limit_r <= pwdata[DATA_W-1:0];
        REG_STAT_FLOOR:    stat_floor_r <= pwdata[DATA_W-1:0];
        REG_MIN_DEVIATION: min_dev_r    <= pwdata[DATA_W-1:0];
        REG_Z_LIMIT:       z_limit_r    <= pwdata[ZLIM_W-1:0];
        REG_WINDOW_LEN:    window_len_r <= pwdata[WLEN_W-1:0];
        REG_RUN_NEEDED:    run_needed_r <= pwdata[RUN_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HARD_LIMIT:    prdata = APB_W'(hard_limit_r);
      REG_STAT_FLOOR:    prdata = APB_W'(stat_floor_r);
      REG_MIN_DEVIATION: prdata = APB_W'(min_dev_r);
      REG_Z_LIMIT:       prdata = APB_W'(z_limit_r);
      REG_WINDOW_LEN:    prdata = APB_W'(window_len_r);
      REG_RUN_NEEDED:    prdata = APB_W'(run_needed_r);
      default:           prdata = '0;
    endcase
  end

  // effective window
  logic [CNT_W-1:0] w_eff;
  always_comb begin
    priority if (window_len_r < WLEN_W'(2)) begin
      w_eff = CNT_W'(2);
    end else if (window_len_r > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(window_len_r);
    end
  end

  // baseline state
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sumsq_r;
  logic [CNT_W-1:0]  fill_r;
  logic [SLOT_W-1:0] slot_r;
  logic [RUN_W-1:0]  run_r;
  logic [SLOT_W-1:0] slot_eff;
  logic [CNT_W-1:0]  slot_inc;
  logic              full;

  assign slot_eff = (CNT_W'(slot_r) < w_eff) ? slot_r : '0;
  assign slot_inc = CNT_W'(slot_eff) + 1'b1;
  assign full     = fill_r >= w_eff;

  // control and working registers
  state_t            state_r, state_nxt;
  logic              launched_r, launched_nxt;
  logic [DATA_W-1:0] value_r;
  logic              smp_valid_r;
  logic [A_W-1:0]    a_r;
  logic [2*SUM_W-1:0] b_r;
  logic [DATA_W-1:0] old_r;
  logic [2*DATA_W-1:0] old_sq_r, new_sq_r;
  logic [DATA_W-1:0] mean_r;
  logic [X_W-1:0]    var_r;
  logic [DATA_W-1:0] dev_r;
  logic [DEN_W-1:0]  den_r;
  logic [DATA_W-1:0] diff_r;
  logic              gt_r, hard_r;
  logic [SCORE_W-1:0] score_z_r, score_h_r;

  // output register
  logic               out_valid_r, trig_r, anom_o_r;
  logic [SCORE_W-1:0] score_o_r;
  logic [DATA_W-1:0]  mean_o_r;

  // shared units
  div_req_t          div_req;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DEN_W-1:0]  div_dvs;
  logic              div_busy, div_done;
  logic              sq_start, sq_done;
  logic [X_W/2-1:0]  sq_root;
  logic              in_acc, fin_go, learn, stat, anom, zterm;
  logic [RUN_W-1:0]  run_new;
  logic [DATA_W-1:0] rdata;
  logic [A_W-1:0]    var_dvd;
  logic [DATA_W-1:0] root24;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign var_dvd  = a_r - A_W'(b_r);
  assign root24   = sq_root[DATA_W-1:0];
  assign zterm    = full && gt_r;

  always_comb begin
    stat = 1'b0;
    if (full && gt_r) begin
      stat = {8'd0, diff_r, 8'd0} >= den_r;
    end else if (full && (value_r == mean_r)) begin
      stat = den_r == '0;
    end
    stat    = stat && (value_r >= stat_floor_r);
    anom    = hard_r || stat;
    run_new = anom ? ((run_r == RUN_MAX) ? RUN_MAX : run_r + 1'b1) : '0;
    learn   = fin_go && smp_valid_r && !anom;
  end

  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    div_req.start = 1'b0;
    div_req.nbits = NB_W'(SUM_W);
    div_dvd       = DVD_W'(sum_r);
    div_dvs       = DEN_W'(fill_r);
    sq_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_sample_valid ? S_MUL : S_FIN;
        end
      end
      S_MUL: state_nxt = S_MEAN;
      S_MEAN: begin
        if (fill_r == '0) begin
          state_nxt = S_VAR;
        end else if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_VAR;
        end
      end
      S_VAR: begin
        div_req.nbits = NB_W'(A_W);
        div_dvd       = DVD_W'(var_dvd);
        div_dvs       = DEN_W'(fill_r * fill_r);
        if (!(fill_r >= CNT_W'(2) && a_r > A_W'(b_r))) begin
          state_nxt = S_SQRT;
        end else if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!launched_r) begin
          sq_start     = 1'b1;
          launched_nxt = 1'b1;
        end else if (sq_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_DEN;
        end
      end
      S_DEN: state_nxt = S_ZDIV;
      S_ZDIV: begin
        div_req.nbits = NB_W'(2 * DATA_W);
        div_dvd       = DVD_W'({diff_r, 24'd0});
        div_dvs       = den_r;
        if (!zterm || den_r == '0) begin
          state_nxt = S_HDIV;
        end else if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_HDIV;
        end
      end
      S_HDIV: begin
        div_req.nbits = NB_W'(DATA_W + 16);
        div_dvd       = DVD_W'({value_r, 16'd0});
        div_dvs       = DEN_W'(hard_limit_r);
        if (hard_limit_r == '0) begin
          state_nxt = S_FIN;
        end else if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r     <= in_sample_value;
      smp_valid_r <= in_sample_valid;
    end
    if (state_r == S_MUL) begin
      a_r      <= A_W'(fill_r * sumsq_r);
      b_r      <= sum_r * sum_r;
      old_r    <= rdata;
      new_sq_r <= value_r * value_r;
      mean_r   <= '0;
      var_r    <= '0;
    end
    if (state_r == S_MEAN && div_done) begin
      mean_r <= div_q[DATA_W-1:0];
    end
    if (state_r == S_VAR && div_done) begin
      var_r <= X_W'(div_q);
    end
    if (state_r == S_SQRT && sq_done) begin
      dev_r <= (root24 < min_dev_r) ? min_dev_r : root24;
    end
    if (state_r == S_DEN) begin
      den_r     <= dev_r * z_limit_r;
      old_sq_r  <= old_r * old_r;
      diff_r    <= value_r - mean_r;
      gt_r      <= value_r > mean_r;
      hard_r    <= value_r >= hard_limit_r;
      score_z_r <= '0;
      score_h_r <= '1;
    end
    if (state_r == S_ZDIV) begin
      if (zterm && den_r == '0) begin
        score_z_r <= '1;
      end else if (div_done) begin
        score_z_r <= (div_q[DVD_W-1:SCORE_W] != '0) ? '1 : div_q[SCORE_W-1:0];
      end
    end
    if (state_r == S_HDIV && div_done) begin
      score_h_r <= (div_q[DVD_W-1:SCORE_W] != '0) ? '1 : div_q[SCORE_W-1:0];
    end
    if (fin_go) begin
      if (smp_valid_r) begin
        trig_r    <= anom && (run_new >= run_needed_r);
        anom_o_r  <= anom;
        score_o_r <= (score_h_r > score_z_r) ? score_h_r : score_z_r;
        mean_o_r  <= mean_r;
      end else begin
        trig_r    <= 1'b0;
        anom_o_r  <= 1'b0;
        score_o_r <= '0;
        mean_o_r  <= '0;
      end
    end
  end

  // baseline and run count
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
      run_r   <= '0;
    end else if (fin_go) begin
      run_r <= smp_valid_r ? run_new : '0;
      if (learn) begin
        if (full) begin
          sum_r   <= sum_r - SUM_W'(old_r) + SUM_W'(value_r);
          sumsq_r <= sumsq_r - SQ_W'(old_sq_r) + SQ_W'(new_sq_r);
        end else begin
          fill_r  <= fill_r + 1'b1;
          sum_r   <= sum_r + SUM_W'(value_r);
          sumsq_r <= sumsq_r + SQ_W'(new_sq_r);
        end
        slot_r <= (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger       = trig_r;
  assign out_anomalous     = anom_o_r;
  assign out_score         = score_o_r;
  assign out_baseline_mean = mean_o_r;

  rzad_ring #(
    .DEPTH(MAX_WINDOW),
    .AW   (SLOT_W)
  ) u_ring (
    .clk  (clk),
    .we   (learn),
    .waddr(slot_eff),
    .wdata(value_r),
    .re   (in_acc),
    .raddr(slot_eff),
    .rdata(rdata)
  );

  rzad_div #(
    .DVD_W(DVD_W),
    .DVS_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .dvd  (div_dvd),
    .dvs  (div_dvs),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_q)
  );

  rzad_sqrt #(
    .X_W(X_W)
  ) u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .x    (var_r),
    .done (sq_done),
    .root (sq_root)
  );

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count beyond window");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_fin_drives_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid && state_r == S_IDLE)
    else $error("result word not presented");

  a_accept_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc)
    else $error("word taken while busy");
`endif

endmodule
